// File: rtl/gli_pkg.sv
// Shared types, constants and helpers for the G-code line interpreter.
`timescale 1ns / 1ps
package gli_pkg;

  // Fixed-point format of parameter values
  localparam int FRACTION_DIGITS = 3;
  localparam int FRAC_W  = $clog2(10 ** FRACTION_DIGITS);
  localparam int FCNT_W  = $clog2(FRACTION_DIGITS + 1);
  localparam int SCALE_W = $clog2(10 ** FRACTION_DIGITS + 1);
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(10 ** FRACTION_DIGITS);

  localparam int LINE_MAX_DEF = 63;
  localparam int QUEUE_DEPTH  = 2;

  // Input actions
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_EOF   = 2'd2;
  localparam logic [1:0] ACT_RSVD  = 2'd3;

  // Command kinds on the output
  localparam logic [2:0] KIND_MOVE  = 3'd0;
  localparam logic [2:0] KIND_HOME  = 3'd1;
  localparam logic [2:0] KIND_SETP  = 3'd2;
  localparam logic [2:0] KIND_HEAT  = 3'd3;
  localparam logic [2:0] KIND_MOFF  = 3'd4;
  localparam logic [2:0] KIND_PROG  = 3'd5;
  localparam logic [2:0] KIND_END   = 3'd6;

  // Register indexes
  localparam logic [1:0] REG_FEED = 2'd0;
  localparam logic [1:0] REG_XOFF = 2'd1;
  localparam logic [1:0] REG_YOFF = 2'd2;
  localparam logic [1:0] REG_ZOFF = 2'd3;

  // Characters
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Command numbers
  localparam logic [7:0] CMD_G0   = 8'd0;
  localparam logic [7:0] CMD_G1   = 8'd1;
  localparam logic [7:0] CMD_G28  = 8'd28;
  localparam logic [7:0] CMD_G90  = 8'd90;
  localparam logic [7:0] CMD_G91  = 8'd91;
  localparam logic [7:0] CMD_G92  = 8'd92;
  localparam logic [7:0] CMD_G161 = 8'd161;
  localparam logic [7:0] CMD_G162 = 8'd162;
  localparam logic [7:0] CMD_M6   = 8'd6;
  localparam logic [7:0] CMD_M18  = 8'd18;
  localparam logic [7:0] CMD_M73  = 8'd73;
  localparam logic [7:0] CMD_M84  = 8'd84;

  typedef enum logic [3:0] {
    PH_START, PH_CMD_FIRST, PH_CMD_DIGITS, PH_SEEK, PH_LETTER,
    PH_SIGN, PH_INT, PH_FRAC, PH_HOME, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {CLS_NONE, CLS_G, CLS_M} cls_t;

  // Work handed from the parser to the executor
  typedef struct packed {
    logic                start;
    logic                eof;
    logic                prm;
    logic                exec;
    logic [7:0]          letter;
    logic                neg;
    logic [31:0]         iacc;
    logic [FRAC_W-1:0]   facc;
    logic [FCNT_W-1:0]   fcnt;
    cls_t                cls;
    logic [7:0]          num;
    logic [2:0]          hmask;
    logic [7:0]          held;
  } evt_t;

  // One result item before offsets are applied
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] e;
    logic signed [31:0] feed;
    logic [2:0]         mask;
    logic [7:0]         num;
  } rec_t;

  // 10 ** (FRACTION_DIGITS - cnt)
  function automatic logic [SCALE_W-1:0] frac_scale(input logic [FCNT_W-1:0] cnt);
    logic [SCALE_W-1:0] r;
    r = SCALE_W'(1);
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      if (i >= int'(cnt)) r = SCALE_W'(r * SCALE_W'(10));
    end
    return r;
  endfunction

  // Saturating signed 32-bit add
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    return s[31:0];
  endfunction

endpackage

// File: rtl/gli_parser.sv
// Front part: byte parser that turns text into parameter and execute work items, and passes start and end items on.
`timescale 1ns / 1ps
module gli_parser #(
  parameter int LINE_MAX = gli_pkg::LINE_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    action,
  input  logic [7:0]    text_byte,
  input  logic          line_end,
  output logic          push,
  output gli_pkg::evt_t push_data
);
  import gli_pkg::*;

  localparam int BC_W = $clog2(LINE_MAX + 1);
  localparam logic [1:0] ARG_NONE = 2'd0, ARG_MULTI = 2'd1, ARG_SINGLE = 2'd2,
                         ARG_HOME = 2'd3;

  function automatic logic [1:0] arg_mode(input cls_t c, input logic [7:0] n);
    logic [1:0] m;
    m = ARG_NONE;
    if (c == CLS_G) begin
      if (n == CMD_G0 || n == CMD_G1 || n == CMD_G92) m = ARG_MULTI;
      else if (n == CMD_G28 || n == CMD_G161 || n == CMD_G162) m = ARG_HOME;
    end else if (c == CLS_M) begin
      if (n == CMD_M6 || n == CMD_M73) m = ARG_SINGLE;
    end
    return m;
  endfunction

  // Tool number or progress kept for an M command
  function automatic logic [7:0] held_calc(input cls_t c, input logic [7:0] n,
                                           input logic [7:0] l, input logic ng,
                                           input logic [31:0] ia, input logic [7:0] h);
    logic [7:0] r;
    r = h;
    if (c == CLS_M) begin
      if (n == CMD_M6 && l == CH_T)
        r = ng ? 8'd0 : ((ia > 32'd255) ? 8'd255 : ia[7:0]);
      else if (n == CMD_M73 && l == CH_P)
        r = ng ? 8'(8'd0 - ia[7:0]) : ia[7:0];
    end
    return r;
  endfunction

  phase_t            ph, ph_next;
  cls_t              cls, cls_next;
  logic [7:0]        num, num_next;
  logic [7:0]        letter, letter_next;
  logic              neg, neg_next;
  logic [31:0]       iacc, iacc_next;
  logic [FRAC_W-1:0] facc, facc_next;
  logic [FCNT_W-1:0] fcnt, fcnt_next;
  logic [2:0]        hmask, hmask_next;
  logic [BC_W-1:0]   bcnt, bcnt_next;
  logic [7:0]        held, held_next;

  logic              is_digit, do_seek, do_home, byte_prm, exec_prm, clear;
  logic [3:0]        dig;
  logic [11:0]       num_mul;
  logic [35:0]       iacc_mul;
  logic [FRAC_W+3:0] facc_mul;
  evt_t              ev;

  always_comb begin
    ph_next = ph; cls_next = cls; num_next = num; letter_next = letter;
    neg_next = neg; iacc_next = iacc; facc_next = facc; fcnt_next = fcnt;
    hmask_next = hmask; bcnt_next = bcnt; held_next = held;
    do_seek = 1'b0; do_home = 1'b0; byte_prm = 1'b0; exec_prm = 1'b0;
    clear = 1'b0;
    is_digit = (text_byte >= CH_0) && (text_byte <= CH_9);
    dig      = 4'(text_byte - CH_0);
    num_mul  = {1'b0, num, 3'b0} + {3'b0, num, 1'b0} + 12'(dig);
    iacc_mul = {1'b0, iacc, 3'b0} + {3'b0, iacc, 1'b0} + 36'(dig);
    facc_mul = (FRAC_W+4)'({facc, 3'b0}) + (FRAC_W+4)'({facc, 1'b0}) + (FRAC_W+4)'(dig);
    ev = '0;

    if (accept && action == ACT_BYTE) begin
      // Per-byte parse, bytes past the line limit are dropped
      if (bcnt < BC_W'(LINE_MAX)) begin
        bcnt_next = bcnt + BC_W'(1);
        case (ph)
          PH_START: begin
            if (text_byte == CH_G) begin
              cls_next = CLS_G; ph_next = PH_CMD_FIRST;
            end else if (text_byte == CH_M) begin
              cls_next = CLS_M; ph_next = PH_CMD_FIRST;
            end else begin
              cls_next = CLS_NONE; ph_next = PH_DONE;
            end
          end
          PH_CMD_FIRST: begin
            if (is_digit) begin
              num_next = {4'd0, dig}; ph_next = PH_CMD_DIGITS;
            end else begin
              cls_next = CLS_NONE; ph_next = PH_DONE;
            end
          end
          PH_CMD_DIGITS: begin
            if (is_digit) begin
              num_next = (num_mul > 12'd255) ? 8'd255 : num_mul[7:0];
            end else begin
              case (arg_mode(cls, num))
                ARG_MULTI, ARG_SINGLE: do_seek = 1'b1;
                ARG_HOME:              do_home = 1'b1;
                default:               ph_next = PH_DONE;
              endcase
            end
          end
          PH_SEEK: do_seek = 1'b1;
          PH_LETTER, PH_SIGN: begin
            if (ph == PH_LETTER && text_byte == CH_MINUS) begin
              neg_next = 1'b1; ph_next = PH_SIGN;
            end else if (is_digit) begin
              iacc_next = 32'(dig); ph_next = PH_INT;
            end else if (text_byte == CH_DOT) begin
              ph_next = PH_FRAC;
            end else begin
              ph_next = PH_DONE;
            end
          end
          PH_INT: begin
            if (is_digit) begin
              iacc_next = (iacc_mul[35:32] != 4'd0) ? 32'hFFFFFFFF : iacc_mul[31:0];
            end else if (text_byte == CH_DOT) begin
              ph_next = PH_FRAC;
            end else begin
              byte_prm = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (int'(fcnt) < FRACTION_DIGITS) begin
                facc_next = FRAC_W'(facc_mul);
                fcnt_next = fcnt + FCNT_W'(1);
              end
            end else begin
              byte_prm = 1'b1;
            end
          end
          PH_HOME: do_home = 1'b1;
          default: ;
        endcase

        // Parameter ended by this byte
        if (byte_prm) begin
          held_next = held_calc(cls, num, letter, neg, iacc, held);
          if (arg_mode(cls, num) == ARG_SINGLE) ph_next = PH_DONE;
          else do_seek = 1'b1;
        end

        // Look for the next parameter letter
        if (do_seek) begin
          if (text_byte == CH_SPACE) begin
            ph_next = PH_SEEK;
          end else if (text_byte >= CH_A && text_byte <= CH_Z) begin
            letter_next = text_byte; neg_next = 1'b0; iacc_next = '0;
            facc_next = '0; fcnt_next = '0; ph_next = PH_LETTER;
          end else begin
            ph_next = PH_DONE;
          end
        end

        // Axis letters of a home command
        if (do_home) begin
          ph_next = PH_HOME;
          if (text_byte >= CH_X && text_byte <= CH_Z)
            hmask_next = hmask | (3'd1 << 2'(text_byte - CH_X));
          else if (text_byte != CH_SPACE)
            ph_next = PH_DONE;
        end
      end

      // Line end: close an open parameter and execute
      if (line_end) begin
        exec_prm = (ph_next == PH_INT) || (ph_next == PH_FRAC);
        if (exec_prm)
          held_next = held_calc(cls_next, num_next, letter_next, neg_next, iacc_next,
                                held_next);
        clear     = 1'b1;
        ev.exec   = 1'b1;
        ev.cls    = (ph_next == PH_CMD_FIRST) ? CLS_NONE : cls_next;
        ev.num    = num_next;
        ev.hmask  = hmask_next;
        ev.held   = held_next;
      end

      // G parameter goes to the executor
      ev.prm = (byte_prm && cls == CLS_G) || (exec_prm && cls_next == CLS_G);
      if (byte_prm) begin
        ev.letter = letter; ev.neg = neg; ev.iacc = iacc; ev.facc = facc; ev.fcnt = fcnt;
      end else begin
        ev.letter = letter_next; ev.neg = neg_next; ev.iacc = iacc_next;
        ev.facc = facc_next; ev.fcnt = fcnt_next;
      end
      if (!ev.exec) begin
        ev.cls = cls;
        ev.num = num;
      end
    end else if (accept && action == ACT_START) begin
      ev.start = 1'b1; clear = 1'b1;
    end else if (accept && action == ACT_EOF) begin
      ev.eof = 1'b1; clear = 1'b1;
    end

    if (clear) begin
      ph_next = PH_START; cls_next = CLS_NONE; num_next = '0; letter_next = '0;
      neg_next = 1'b0; iacc_next = '0; facc_next = '0; fcnt_next = '0;
      hmask_next = '0; bcnt_next = '0; held_next = '0;
    end
  end

  assign push      = ev.start | ev.eof | ev.prm | ev.exec;
  assign push_data = ev;

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_START; cls <= CLS_NONE; num <= '0; letter <= '0; neg <= 1'b0;
      iacc <= '0; facc <= '0; fcnt <= '0; hmask <= '0; bcnt <= '0; held <= '0;
    end else begin
      ph <= ph_next; cls <= cls_next; num <= num_next; letter <= letter_next;
      neg <= neg_next; iacc <= iacc_next; facc <= facc_next; fcnt <= fcnt_next;
      hmask <= hmask_next; bcnt <= bcnt_next; held <= held_next;
    end
  end

endmodule

// File: rtl/gli_queue.sv
// Short queue of work items between the parser and the executor.
`timescale 1ns / 1ps
module gli_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gli_pkg::evt_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output gli_pkg::evt_t pop_data
);
  import gli_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  evt_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] cnt;

  assign full     = (cnt == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt == '0);
  assign pop_data = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; cnt <= '0;
    end else begin
      if (push)
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop)
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      if (push && !pop) cnt <= cnt + CNT_W'(1);
      else if (pop && !push) cnt <= cnt - CNT_W'(1);
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop)) else $error("push into full queue");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + CNT_W'(1)) else $error("count not raised");
`endif

endmodule

// File: rtl/gli_exec.sv
// Back part: scales values, keeps positions and mode, builds and sends result items.
`timescale 1ns / 1ps
module gli_exec (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  gli_pkg::evt_t q_data,
  output logic          q_pop,
  input  logic [30:0]   base_feed,
  input  logic [31:0]   ofs_x,
  input  logic [31:0]   ofs_y,
  input  logic [31:0]   ofs_z,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    command_kind,
  output logic [31:0]   pos_x,
  output logic [31:0]   pos_y,
  output logic [31:0]   pos_z,
  output logic [31:0]   pos_e,
  output logic [31:0]   feed,
  output logic [2:0]    axis_mask,
  output logic [7:0]    number_value
);
  import gli_pkg::*;

  localparam int MAG_W = 32 + SCALE_W + 1;

  logic               s1v, cv;
  evt_t               s1;
  logic signed [31:0] s1val, val;
  logic [MAG_W-1:0]   mag;
  logic               s1_take, c_take, out_load;

  logic signed [31:0] cx, cy, cz, ce, fr, cx_next, cy_next, cz_next, ce_next, fr_next;
  logic               rel, rel_next, rec_ok;
  rec_t               crec, rec;

  assign out_load = !out_valid || !out_stall;
  assign c_take   = cv && out_load;
  assign s1_take  = s1v && (!cv || c_take);
  assign q_pop    = !q_empty && (!s1v || s1_take);

  // Stage 1: fixed-point value of the parameter
  always_comb begin
    mag = MAG_W'(q_data.iacc) * MAG_W'(SCALE)
        + MAG_W'(q_data.facc) * MAG_W'(frac_scale(q_data.fcnt));
    if (q_data.neg)
      val = (mag > MAG_W'(33'h080000000)) ? 32'sh80000000 : 32'(33'd0 - mag[32:0]);
    else
      val = (mag > MAG_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) s1v <= 1'b0;
    else if (q_pop) s1v <= 1'b1;
    else if (s1_take) s1v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= q_data; s1val <= val;
    end
  end

  // Stage 2: apply parameter, then execute the line
  always_comb begin
    logic move;
    cx_next = cx; cy_next = cy; cz_next = cz; ce_next = ce; fr_next = fr;
    rel_next = rel; rec = '0; rec_ok = 1'b0;
    move = (s1.num != CMD_G92);
    if (s1.start) begin
      cx_next = '0; cy_next = '0; cz_next = '0; ce_next = '0;
      fr_next = {1'b0, base_feed}; rel_next = 1'b0;
    end
    if (s1.prm) begin
      case (s1.letter)
        CH_X: cx_next = (move && rel) ? sat_add(cx, s1val) : s1val;
        CH_Y: cy_next = (move && rel) ? sat_add(cy, s1val) : s1val;
        CH_Z: cz_next = (move && rel) ? sat_add(cz, s1val) : s1val;
        CH_E: ce_next = (move && rel) ? sat_add(ce, s1val) : s1val;
        CH_F: if (move) fr_next = s1val;
        default: ;
      endcase
    end
    if (s1.exec && s1.cls == CLS_G) begin
      case (s1.num)
        CMD_G0, CMD_G1: begin
          if (s1.num == CMD_G0) fr_next = {1'b0, base_feed};
          rec.kind = KIND_MOVE; rec.x = cx_next; rec.y = cy_next; rec.z = cz_next;
          rec.e = ce_next; rec.feed = fr_next; rec_ok = 1'b1;
        end
        CMD_G28: begin
          rec.kind = KIND_HOME; rec.mask = (s1.hmask != 3'd0) ? s1.hmask : 3'd7;
          rec_ok = 1'b1;
        end
        CMD_G161, CMD_G162: begin
          rec.kind = KIND_HOME; rec.mask = s1.hmask; rec_ok = 1'b1;
        end
        CMD_G90: rel_next = 1'b0;
        CMD_G91: rel_next = 1'b1;
        CMD_G92: begin
          rec.kind = KIND_SETP; rec.x = cx_next; rec.y = cy_next; rec.z = cz_next;
          rec.e = ce_next; rec_ok = 1'b1;
        end
        default: ;
      endcase
    end else if (s1.exec && s1.cls == CLS_M) begin
      case (s1.num)
        CMD_M6:          begin rec.kind = KIND_HEAT; rec.num = s1.held; rec_ok = 1'b1; end
        CMD_M18, CMD_M84: begin rec.kind = KIND_MOFF; rec_ok = 1'b1; end
        CMD_M73:         begin rec.kind = KIND_PROG; rec.num = s1.held; rec_ok = 1'b1; end
        default: ;
      endcase
    end
    if (s1.eof) begin
      rec.kind = KIND_END; rec_ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0; cy <= '0; cz <= '0; ce <= '0; fr <= 32'sd3000000; rel <= 1'b0;
      cv <= 1'b0;
    end else begin
      if (s1_take) begin
        cx <= cx_next; cy <= cy_next; cz <= cz_next; ce <= ce_next; fr <= fr_next;
        rel <= rel_next;
        cv <= rec_ok;
      end else if (c_take) begin
        cv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) crec <= rec;
  end

  // Stage 3: output register with offsets on move and set position
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= cv;
  end

  always_ff @(posedge clk) begin
    if (c_take) begin
      command_kind <= crec.kind;
      if (crec.kind == KIND_MOVE || crec.kind == KIND_SETP) begin
        pos_x <= sat_add(crec.x, ofs_x);
        pos_y <= sat_add(crec.y, ofs_y);
        pos_z <= sat_add(crec.z, ofs_z);
      end else begin
        pos_x <= '0; pos_y <= '0; pos_z <= '0;
      end
      pos_e        <= crec.e;
      feed         <= crec.feed;
      axis_mask    <= crec.mask;
      number_value <= crec.num;
    end
  end

endmodule

// File: rtl/gcode_line_interpreter.sv
// Top level of the G-code line interpreter: register port, parser, queue, executor.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid / in_stall  | action, text_byte, line_end
//  out     | out | out_valid / out_stall| command_kind, pos_x..pos_e, feed, axis_mask,
//          |     |                      | number_value
//  config  | in  | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One item per cycle while in_stall is low; the parser handles each byte in the cycle it is taken.
// A result for a line-end item passes through the work queue and the registered scale, execute and offset stages.
// Reset is synchronous: positions, mode and line state clear, registers take defaults.
// in_stall rises only when the two-entry work queue is full; out_stall backs up
// through the executor into that queue.
`timescale 1ns / 1ps
module gcode_line_interpreter #(
  parameter int LINE_MAX = gli_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  text_byte,
  input  logic        line_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  command_kind,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic [31:0] pos_e,
  output logic [31:0] feed,
  output logic [2:0]  axis_mask,
  output logic [7:0]  number_value
);
  import gli_pkg::*;

  logic [30:0] base_feed;
  logic [31:0] ofs_x, ofs_y, ofs_z;
  logic        push, full, pop, empty;
  evt_t        push_data, pop_data;

  assign pready   = 1'b1;
  assign in_stall = full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_feed <= 31'd3000000;
      ofs_x <= '0; ofs_y <= '0; ofs_z <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FEED: base_feed <= pwdata[30:0];
        REG_XOFF: ofs_x <= pwdata;
        REG_YOFF: ofs_y <= pwdata;
        REG_ZOFF: ofs_z <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (paddr[3:2])
      REG_FEED: prdata = {1'b0, base_feed};
      REG_XOFF: prdata = ofs_x;
      REG_YOFF: prdata = ofs_y;
      REG_ZOFF: prdata = ofs_z;
      default:  prdata = '0;
    endcase
  end

  gli_parser #(.LINE_MAX(LINE_MAX)) u_parser (
    .clk, .rst,
    .accept(in_valid && !in_stall),
    .action, .text_byte, .line_end,
    .push, .push_data
  );

  gli_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .empty, .pop_data
  );

  gli_exec u_exec (
    .clk, .rst,
    .q_empty(empty), .q_data(pop_data), .q_pop(pop),
    .base_feed, .ofs_x, .ofs_y, .ofs_z,
    .out_valid, .out_stall, .command_kind, .pos_x, .pos_y, .pos_z, .pos_e,
    .feed, .axis_mask, .number_value
  );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the G-code line interpreter.
`timescale 1ns / 1ps
module tb_top;
  import gli_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] e;
    logic [31:0] fd;
    logic [2:0]  mask;
    logic [7:0]  num;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_BYTE;
  logic [7:0] text_byte = '0;
  logic line_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] command_kind;
  logic [31:0] pos_x, pos_y, pos_z, pos_e, feed;
  logic [2:0] axis_mask;
  logic [7:0] number_value;

  gcode_line_interpreter uut (.*);

  always #5 clk = ~clk;

  // Idle and stall rates in percent, long hold-off length
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  int errors = 0;
  int cycles = 0;
  cmd_t expected_cmds[$];

  // Predictor state
  logic [30:0] m_deffeed;
  logic signed [31:0] m_xoff, m_yoff, m_zoff;
  logic signed [31:0] m_x, m_y, m_z, m_e, m_feed;
  logic m_rel;
  phase_t m_ph;
  cls_t m_cls;
  logic [7:0] m_num, m_letter, m_held;
  logic m_neg;
  logic [31:0] m_iacc;
  int unsigned m_facc, m_fcnt, m_bytes;
  logic [2:0] m_hmask;

  function automatic logic signed [31:0] sat64(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] param_val();
    longint mag;
    mag = longint'(m_iacc) * 1000;
    mag += longint'(m_facc) * (m_fcnt == 0 ? 1000 : m_fcnt == 1 ? 100 : m_fcnt == 2 ? 10 : 1);
    if (m_neg) return sat64(-mag);
    return sat64(mag);
  endfunction

  function automatic bit is_multi();
    return (m_cls == CLS_G) && (m_num == CMD_G0 || m_num == CMD_G1 || m_num == CMD_G92);
  endfunction
  function automatic bit is_single();
    return (m_cls == CLS_M) && (m_num == CMD_M6 || m_num == CMD_M73);
  endfunction
  function automatic bit is_home();
    return (m_cls == CLS_G) && (m_num == CMD_G28 || m_num == CMD_G161 || m_num == CMD_G162);
  endfunction

  function automatic logic signed [31:0] axis_next(logic signed [31:0] a,
                                                   logic signed [31:0] v, bit mv);
    if (mv && m_rel) return sat64(longint'(a) + longint'(v));
    return v;
  endfunction

  task automatic apply_param();
    logic signed [31:0] v;
    bit mv;
    v = param_val();
    mv = (m_num != CMD_G92);
    if (m_cls == CLS_G) begin
      case (m_letter)
        CH_X: m_x = axis_next(m_x, v, mv);
        CH_Y: m_y = axis_next(m_y, v, mv);
        CH_Z: m_z = axis_next(m_z, v, mv);
        CH_E: m_e = axis_next(m_e, v, mv);
        CH_F: if (mv) m_feed = v;
        default: ;
      endcase
    end else if (m_cls == CLS_M) begin
      if (m_num == CMD_M6 && m_letter == CH_T)
        m_held = m_neg ? 8'd0 : (m_iacc > 255 ? 8'd255 : m_iacc[7:0]);
      else if (m_num == CMD_M73 && m_letter == CH_P)
        m_held = m_neg ? 8'(0 - m_iacc[7:0]) : m_iacc[7:0];
    end
  endtask

  task automatic seek_letter(logic [7:0] c);
    if (c == CH_SPACE) m_ph = PH_SEEK;
    else if (c >= CH_A && c <= CH_Z) begin
      m_letter = c; m_neg = 0; m_iacc = 0; m_facc = 0; m_fcnt = 0; m_ph = PH_LETTER;
    end else m_ph = PH_DONE;
  endtask

  task automatic home_seek(logic [7:0] c);
    m_ph = PH_HOME;
    if (c == CH_SPACE) return;
    if (c >= CH_X && c <= CH_Z) m_hmask |= 3'(1 << (c - CH_X));
    else m_ph = PH_DONE;
  endtask

  task automatic after_param(logic [7:0] c);
    apply_param();
    if (is_single()) m_ph = PH_DONE;
    else seek_letter(c);
  endtask

  task automatic parse_char(logic [7:0] c);
    bit dig;
    logic [31:0] d;
    longint n;
    dig = (c >= CH_0 && c <= CH_9);
    d = 32'(c - CH_0);
    case (m_ph)
      PH_START:
        if (c == CH_G) begin m_cls = CLS_G; m_ph = PH_CMD_FIRST; end
        else if (c == CH_M) begin m_cls = CLS_M; m_ph = PH_CMD_FIRST; end
        else begin m_cls = CLS_NONE; m_ph = PH_DONE; end
      PH_CMD_FIRST:
        if (dig) begin m_num = d[7:0]; m_ph = PH_CMD_DIGITS; end
        else begin m_cls = CLS_NONE; m_ph = PH_DONE; end
      PH_CMD_DIGITS:
        if (dig) begin
          n = longint'(m_num) * 10 + d;
          m_num = n > 255 ? 8'd255 : n[7:0];
        end else if (is_multi() || is_single()) seek_letter(c);
        else if (is_home()) home_seek(c);
        else m_ph = PH_DONE;
      PH_SEEK: seek_letter(c);
      PH_LETTER, PH_SIGN:
        if (m_ph == PH_LETTER && c == CH_MINUS) begin m_neg = 1; m_ph = PH_SIGN; end
        else if (dig) begin m_iacc = d; m_ph = PH_INT; end
        else if (c == CH_DOT) m_ph = PH_FRAC;
        else m_ph = PH_DONE;
      PH_INT:
        if (dig) begin
          n = longint'(m_iacc) * 10 + d;
          m_iacc = n > 64'hFFFFFFFF ? 32'hFFFFFFFF : n[31:0];
        end else if (c == CH_DOT) m_ph = PH_FRAC;
        else after_param(c);
      PH_FRAC:
        if (dig) begin
          if (m_fcnt < FRACTION_DIGITS) begin m_facc = m_facc * 10 + d; m_fcnt++; end
        end else after_param(c);
      PH_HOME: home_seek(c);
      default: ;
    endcase
  endtask

  task automatic clear_line();
    m_ph = PH_START; m_cls = CLS_NONE; m_num = 0; m_letter = 0; m_neg = 0;
    m_iacc = 0; m_facc = 0; m_fcnt = 0; m_hmask = 0; m_bytes = 0; m_held = 0;
  endtask

  task automatic start_job();
    m_x = 0; m_y = 0; m_z = 0; m_e = 0; m_feed = {1'b0, m_deffeed}; m_rel = 0;
  endtask

  task automatic fill_pos(inout cmd_t r);
    r.x = sat64(longint'(m_x) + longint'(m_xoff));
    r.y = sat64(longint'(m_y) + longint'(m_yoff));
    r.z = sat64(longint'(m_z) + longint'(m_zoff));
    r.e = m_e;
  endtask

  // Run the finished line and queue the command it yields, if any
  task automatic run_line();
    cmd_t r;
    bit hit;
    r = '0;
    hit = 0;
    if (m_ph == PH_INT || m_ph == PH_FRAC) apply_param();
    if (m_ph == PH_CMD_FIRST) m_cls = CLS_NONE;
    if (m_cls == CLS_G) begin
      case (m_num)
        CMD_G0, CMD_G1: begin
          if (m_num == CMD_G0) m_feed = {1'b0, m_deffeed};
          r.kind = KIND_MOVE; fill_pos(r); r.fd = m_feed; hit = 1;
        end
        CMD_G28: begin r.kind = KIND_HOME; r.mask = m_hmask ? m_hmask : 3'd7; hit = 1; end
        CMD_G161, CMD_G162: begin r.kind = KIND_HOME; r.mask = m_hmask; hit = 1; end
        CMD_G90: m_rel = 0;
        CMD_G91: m_rel = 1;
        CMD_G92: begin r.kind = KIND_SETP; fill_pos(r); hit = 1; end
        default: ;
      endcase
    end else if (m_cls == CLS_M) begin
      case (m_num)
        CMD_M6: begin r.kind = KIND_HEAT; r.num = m_held; hit = 1; end
        CMD_M18, CMD_M84: begin r.kind = KIND_MOFF; hit = 1; end
        CMD_M73: begin r.kind = KIND_PROG; r.num = m_held; hit = 1; end
        default: ;
      endcase
    end
    clear_line();
    if (hit) expected_cmds.push_back(r);
  endtask

  // Predict the effect of one accepted item
  task automatic predict_item(logic [1:0] act, logic [7:0] c, logic le);
    cmd_t r;
    if (act == ACT_START) begin start_job(); clear_line(); end
    else if (act == ACT_EOF) begin
      clear_line();
      r = '0; r.kind = KIND_END;
      expected_cmds.push_back(r);
    end else if (act == ACT_BYTE) begin
      if (m_bytes < LINE_MAX_DEF) begin m_bytes++; parse_char(c); end
      if (le) run_line();
    end
  endtask

  // Send one item, waiting out idles and stalls; valid stays up until the next idle
  task automatic send_item(logic [1:0] act, logic [7:0] c, logic le);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; action <= act; text_byte <= c; line_end <= le;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(act, c, le);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i], i == s.len() - 1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FEED: m_deffeed = val[30:0];
      REG_XOFF: m_xoff = val;
      REG_YOFF: m_yoff = val;
      default:  m_zoff = val;
    endcase
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cmd_t got, want;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = {command_kind, pos_x, pos_y, pos_z, pos_e, feed, axis_mask, number_value};
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected command kind %0d", command_kind);
      end else begin
        want = expected_cmds.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %h got %h", want, got);
        end
      end
    end
  end

  // Receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_char();
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1, 2: return CH_SPACE;
      3: return CH_MINUS;
      4: return CH_DOT;
      5: begin
        case ($urandom_range(6))
          0: return CH_X; 1: return CH_Y; 2: return CH_Z; 3: return CH_E;
          4: return CH_F; 5: return CH_T; default: return CH_P;
        endcase
      end
      default: return 8'(CH_0 + $urandom_range(9));
    endcase
  endfunction

  function automatic string rand_cmd();
    case ($urandom_range(15))
      0: return "G0"; 1, 2, 3: return "G1"; 4: return "G28"; 5: return "G161";
      6: return "G162"; 7: return "G90"; 8: return "G91"; 9: return "G92";
      10: return "M6"; 11: return "M18"; 12: return "M84"; 13: return "M73";
      14: return $sformatf("G%0d", $urandom_range(999));
      default: return $sformatf("M%0d", $urandom_range(300));
    endcase
  endfunction

  function automatic string rand_num();
    string s;
    s = $urandom_range(3) == 0 ? "-" : "";
    if ($urandom_range(9) == 0) s = {s, "99999999999"};
    else s = {s, $sformatf("%0d", $urandom_range($urandom_range(1) ? 300 : 3000000))};
    if ($urandom_range(1)) s = {s, ".", $sformatf("%0d", $urandom_range(99999))};
    return s;
  endfunction

  // Mostly well-formed lines, some noise, occasional job control
  task automatic random_lines(int n_items);
    string s;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: begin send_item(ACT_START, 8'($urandom), 1'($urandom)); sent++; continue; end
        1: begin send_item(ACT_EOF, 8'($urandom), 1'($urandom)); sent++; continue; end
        2: begin
          s = "";
          repeat ($urandom_range(1, 12)) s = {s, string'(rand_char())};
        end
        default: begin
          s = rand_cmd();
          repeat ($urandom_range(0, 4)) begin
            s = {s, " ", string'(rand_char() | 8'h40 & 8'h5F)};
            if ($urandom_range(5) == 0) s = {s, " ", rand_cmd()};
            else begin
              case ($urandom_range(4))
                0: s = {s, " X"}; 1: s = {s, " Y"}; 2: s = {s, " Z"};
                3: s = {s, " E"}; default: s = {s, " F"};
              endcase
              s = {s, rand_num()};
            end
          end
          if (s[0] == "M") s = {s, $urandom_range(1) ? " T" : " P", rand_num()};
          if ($urandom_range(15) == 0) s = {s, "XYZ 123 456 789 012 345 678 901 234 567 890 12"};
        end
      endcase
      if (s.len() > 0 && s[s.len()-1] == " ") s = {s, "X1"};
      send_line(s);
      sent += s.len();
    end
  endtask

  task automatic test_directed();
    send_item(ACT_START, 8'h00, 1'b0);
    send_line("G1 X1.5 Y-2.25 Z0.0001 E7 F1200");
    send_line("G0 X-0.9999");
    send_line("G91");
    send_line("G1 X2147483 Y-99999999999");
    send_line("G90");
    send_line("G92 X0 E-1");
    send_line("G28");
    send_line("G28 X Z");
    send_line("G161");
    send_line("G162 Y");
    send_line("M6 T300");
    send_line("M6 T-4");
    send_line("M73 P-1");
    send_line("M73 P511");
    send_line("M18");
    send_line("M84");
    send_line("M999");
    send_line("G");
    send_line("Q1");
    send_line("G1 X5 ?Y9");
    send_line("G1 X1 Y1 Z1 E1 F1 X2 Y2 Z2 E2 F2 X3 Y3 Z3 E3 F3 X4 Y4 Z4 E4 F4 X5");
    send_item(ACT_BYTE, CH_G, 1'b0);
    send_item(ACT_START, 8'h00, 1'b0);
    send_item(ACT_BYTE, CH_M, 1'b0);
    send_item(ACT_EOF, 8'h00, 1'b0);
    send_item(ACT_RSVD, 8'hFF, 1'b1);
  endtask

  task automatic test_offsets(logic [31:0] fd, logic [31:0] xo, logic [31:0] yo,
                              logic [31:0] zo);
    wait_drain();
    write_reg(REG_FEED, fd);
    write_reg(REG_XOFF, xo);
    write_reg(REG_YOFF, yo);
    write_reg(REG_ZOFF, zo);
    send_item(ACT_START, 8'h00, 1'b0);
    send_line("G0 X2147483.647 Y-2147483.648 Z1");
    send_line("G92 X-2147483.648 Y2147483.647");
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    random_lines(100);
    wait_drain();
  endtask

  task automatic test_random_phases();
    send_idle = 0;  recv_stall = 0;  random_lines(130);
    send_idle = 70; recv_stall = 0;  random_lines(130);
    send_idle = 0;  recv_stall = 70; random_lines(130);
    send_idle = 34; recv_stall = 34; random_lines(130);
    send_idle = 0;  recv_stall = 0;
  endtask

  initial begin
    m_deffeed = 31'd3000000; m_xoff = 0; m_yoff = 0; m_zoff = 0;
    start_job();
    clear_line();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_offsets(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    test_offsets(32'h0, 32'h80000000, 32'h7FFFFFFF, 32'd1000);
    test_backpressure();
    test_random_phases();
    test_offsets(32'd3000000, 32'd12345, 32'hFFFF0000, 32'd0);
    random_lines(40);
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_cmds.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
